### src/mcm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcm_pkg
// shared widths, limits and the lane result type for the color moments block
// ----------------------------------------------------------------------------
package mcm_pkg;

  localparam int CNT_W = 17;
  localparam int S1_W  = 24;
  localparam int S2_W  = 32;
  localparam int S3_W  = 40;

  localparam logic [CNT_W-1:0] MAX_REGION_PIXELS = 17'd65536;

  typedef struct packed {
    logic               done;
    logic [15:0]        mean;
    logic [15:0]        spread;
    logic signed [16:0] skew;
  } lane_res_t;

endpackage

### src/mcm_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcm_lane
// one color channel: running sums of value, square and cube, then a serial
// finish (shift-add multiplier, restoring divider, square and cube root)
// ----------------------------------------------------------------------------
module mcm_lane
  import mcm_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             pix_en,
  input  logic [7:0]       pix,
  input  logic             go,
  input  logic [CNT_W-1:0] n,
  output lane_res_t        res
);

  localparam logic [3:0] PH_IDLE  = 4'd0;
  localparam logic [3:0] PH_SQ    = 4'd1;
  localparam logic [3:0] PH_NS2   = 4'd2;
  localparam logic [3:0] PH_NS1   = 4'd3;
  localparam logic [3:0] PH_NS1S2 = 4'd4;
  localparam logic [3:0] PH_NN    = 4'd5;
  localparam logic [3:0] PH_NNS3  = 4'd6;
  localparam logic [3:0] PH_SQS1  = 4'd7;
  localparam logic [3:0] PH_DIVM  = 4'd8;
  localparam logic [3:0] PH_SQRT  = 4'd9;
  localparam logic [3:0] PH_DIVS  = 4'd10;
  localparam logic [3:0] PH_CBRT  = 4'd11;
  localparam logic [3:0] PH_DIVK  = 4'd12;

  // input stage
  logic        p_en;
  logic        p_go;
  logic [7:0]  p_v;
  logic [15:0] p_v2;

  logic [S1_W-1:0] s1;
  logic [S2_W-1:0] s2;
  logic [S3_W-1:0] s3;

  logic [3:0]  phase;
  logic        run;
  logic [5:0]  cnt;

  logic [79:0] ma;
  logic [39:0] mb;
  logic [79:0] prod;
  logic [47:0] sq;
  logic [49:0] dv;
  logic [79:0] tmp;
  logic [79:0] pos;
  logic [79:0] neg;
  logic        kneg;

  logic [71:0] rem;
  logic [98:0] xs;
  logic [33:0] yr;
  logic [67:0] y2;

  logic        done;
  logic [15:0] mean;
  logic [15:0] spread;
  logic [16:0] skew;

  logic [79:0] mul_a;
  logic [39:0] mul_b;
  logic [79:0] prod_step;
  logic [33:0] div_in;
  logic [71:0] div_sh;
  logic        div_ge;
  logic [71:0] div_rem;
  logic [15:0] div_q;
  logic [71:0] sq_sh;
  logic [71:0] sq_trial;
  logic        sq_ge;
  logic [33:0] cb_yd;
  logic [71:0] cb_yd_w;
  logic [71:0] cb_y2d;
  logic [71:0] cb_b;
  logic [71:0] cb_sh;
  logic        cb_ge;
  logic        mag_neg;
  logic [79:0] mag;
  logic        fin;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_en <= 1'b0;
      p_go <= 1'b0;
    end else begin
      p_en <= pix_en;
      p_go <= go;
    end
    p_v  <= pix;
    p_v2 <= 16'(pix * pix);
  end

  assign fin = (phase == PH_DIVK) && run && (cnt == 6'd0);

  always_ff @(posedge clk) begin
    if (rst || fin) begin
      s1 <= '0;
      s2 <= '0;
      s3 <= '0;
    end else if (p_en) begin
      s1 <= s1 + S1_W'(p_v);
      s2 <= s2 + S2_W'(p_v2);
      s3 <= s3 + S3_W'(p_v2 * p_v);
    end
  end

  always_comb begin
    case (phase)
      PH_SQ:    begin mul_a = 80'(s1);  mul_b = 40'(s1); end
      PH_NS2:   begin mul_a = 80'(s2);  mul_b = 40'(n);  end
      PH_NS1:   begin mul_a = 80'(s1);  mul_b = 40'(n);  end
      PH_NS1S2: begin mul_a = tmp;      mul_b = 40'(s2); end
      PH_NN:    begin mul_a = 80'(n);   mul_b = 40'(n);  end
      PH_NNS3:  begin mul_a = tmp;      mul_b = s3;      end
      PH_SQS1:  begin mul_a = 80'(sq);  mul_b = 40'(s1); end
      default:  begin mul_a = '0;       mul_b = '0;      end
    endcase
  end

  assign prod_step = mb[0] ? prod + ma : prod;

  assign div_in  = (phase == PH_DIVM) ? {2'b00, s1, 8'h00} : yr;
  assign div_sh  = {rem[70:0], xs[98]};
  assign div_ge  = div_sh >= 72'(n);
  assign div_rem = div_ge ? div_sh - 72'(n) : div_sh;
  assign div_q   = {yr[14:0], div_ge};

  assign sq_sh    = {rem[69:0], xs[98:97]};
  assign sq_trial = 72'({yr, 2'b01});
  assign sq_ge    = sq_sh >= sq_trial;

  // b = 3*y*(y+1) + 1 from the running square, no multiplier needed
  assign cb_yd   = {yr[32:0], 1'b0};
  assign cb_yd_w = 72'(cb_yd);
  assign cb_y2d  = 72'({y2[65:0], 2'b00});
  assign cb_b    = cb_y2d + {cb_y2d[70:0], 1'b0} + cb_yd_w + {cb_yd_w[70:0], 1'b0} + 72'd1;
  assign cb_sh   = {rem[68:0], xs[98:96]};
  assign cb_ge   = cb_sh >= cb_b;

  assign mag_neg = neg > pos;
  assign mag     = mag_neg ? neg - pos : pos - neg;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      run   <= 1'b0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (phase) inside
        PH_IDLE: begin
          run <= 1'b0;
          if (p_go) begin
            phase <= PH_SQ;
          end
        end
        PH_SQ, PH_NS2, PH_NS1, PH_NS1S2, PH_NN, PH_NNS3, PH_SQS1: begin
          if (!run) begin
            ma   <= mul_a;
            mb   <= mul_b;
            prod <= '0;
            cnt  <= 6'd39;
            run  <= 1'b1;
          end else begin
            prod <= prod_step;
            ma   <= {ma[78:0], 1'b0};
            mb   <= {1'b0, mb[39:1]};
            cnt  <= cnt - 6'd1;
            if (cnt == 6'd0) begin
              run   <= 1'b0;
              phase <= phase + 4'd1;
              case (phase)
                PH_SQ:    sq  <= prod_step[47:0];
                PH_NS2:   dv  <= (prod_step[49:0] >= 50'(sq)) ?
                                 prod_step[49:0] - 50'(sq) : '0;
                PH_NS1:   tmp <= prod_step;
                PH_NS1S2: pos <= prod_step + {prod_step[78:0], 1'b0};
                PH_NN:    tmp <= prod_step;
                PH_NNS3:  neg <= prod_step;
                default:  neg <= neg + {prod_step[78:0], 1'b0};
              endcase
            end
          end
        end
        PH_DIVM, PH_DIVS, PH_DIVK: begin
          if (!run) begin
            rem <= 72'(div_in[33:16]);
            xs  <= {div_in[15:0], 83'd0};
            yr  <= '0;
            cnt <= 6'd15;
            run <= 1'b1;
          end else begin
            rem <= div_rem;
            xs  <= {xs[97:0], 1'b0};
            yr  <= {yr[32:0], div_ge};
            cnt <= cnt - 6'd1;
            if (cnt == 6'd0) begin
              run <= 1'b0;
              case (phase)
                PH_DIVM: begin
                  mean  <= div_q;
                  phase <= PH_SQRT;
                end
                PH_DIVS: begin
                  spread <= div_q;
                  phase  <= PH_CBRT;
                end
                default: begin
                  skew  <= kneg ? 17'd0 - {1'b0, div_q} : {1'b0, div_q};
                  done  <= 1'b1;
                  phase <= PH_IDLE;
                end
              endcase
            end
          end
        end
        PH_SQRT: begin
          if (!run) begin
            rem <= '0;
            xs  <= {2'b00, dv, 16'h0000, 31'd0};
            yr  <= '0;
            cnt <= 6'd33;
            run <= 1'b1;
          end else begin
            rem <= sq_ge ? sq_sh - sq_trial : sq_sh;
            xs  <= {xs[96:0], 2'b00};
            yr  <= {yr[32:0], sq_ge};
            cnt <= cnt - 6'd1;
            if (cnt == 6'd0) begin
              run   <= 1'b0;
              phase <= PH_DIVS;
            end
          end
        end
        PH_CBRT: begin
          if (!run) begin
            rem  <= '0;
            y2   <= '0;
            yr   <= '0;
            xs   <= {mag[74:0], 24'd0};
            kneg <= mag_neg;
            cnt  <= 6'd32;
            run  <= 1'b1;
          end else begin
            xs  <= {xs[95:0], 3'b000};
            cnt <= cnt - 6'd1;
            if (cb_ge) begin
              rem <= cb_sh - cb_b;
              yr  <= cb_yd + 34'd1;
              y2  <= 68'(cb_y2d + {cb_yd_w[70:0], 1'b0} + 72'd1);
            end else begin
              rem <= cb_sh;
              yr  <= cb_yd;
              y2  <= 68'(cb_y2d);
            end
            if (cnt == 6'd0) begin
              run   <= 1'b0;
              phase <= PH_DIVK;
            end
          end
        end
        default: begin
          phase <= PH_IDLE;
          run   <= 1'b0;
        end
      endcase
    end
  end

  assign res.done   = done;
  assign res.mean   = mean;
  assign res.spread = spread;
  assign res.skew   = skew;

endmodule

### src/masked_color_moments_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// masked_color_moments_top
// mean, standard deviation and skew root of a masked three-channel region
// ----------------------------------------------------------------------------
// usage:
//   a pixel word is taken on each edge with start high and busy low, so
//   pixels stream in one per cycle. mask_on clear skips the pixel, and
//   counting stops at 65536 masked pixels.
//   last_pixel ends the region: busy rises, three channel lanes run their
//   serial finish in parallel and the merge stage registers one result
//   word, marked by done for exactly one cycle. the finish is 7 multiplies
//   on the shift-add multiplier, 3 divides, a square root and a cube root,
//   plus the input and output stages.
//   busy drops on the edge that shows done, so the next region may start on
//   the following cycle.
//   an empty region gives region_empty high and zeros elsewhere.
//   the receiver cannot stall; the result must be taken when done is high.
//   synchronous reset clears the count, the sums and all control state.
// ----------------------------------------------------------------------------
module masked_color_moments_top
  import mcm_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [7:0]         chan_a,
  input  logic [7:0]         chan_b,
  input  logic [7:0]         chan_c,
  input  logic               mask_on,
  input  logic               last_pixel,
  output logic               done,
  output logic [15:0]        mean_a,
  output logic [15:0]        mean_b,
  output logic [15:0]        mean_c,
  output logic [15:0]        spread_a,
  output logic [15:0]        spread_b,
  output logic [15:0]        spread_c,
  output logic signed [16:0] skew_a,
  output logic signed [16:0] skew_b,
  output logic signed [16:0] skew_c,
  output logic               region_empty,
  output logic [16:0]        pixels_counted
);

  logic             accept;
  logic             pix_en;
  logic [CNT_W-1:0] count;
  logic [7:0]       pix [3];
  lane_res_t        lres [3];
  logic             lanes_done;
  logic             empty;

  assign accept = start && !busy;
  assign pix_en = accept && mask_on && (count < MAX_REGION_PIXELS);
  assign pix[0] = chan_a;
  assign pix[1] = chan_b;
  assign pix[2] = chan_c;

  for (genvar i = 0; i < 3; i++) begin : g_lane
    mcm_lane u_lane (
      .clk    (clk),
      .rst    (rst),
      .pix_en (pix_en),
      .pix    (pix[i]),
      .go     (accept && last_pixel),
      .n      (count),
      .res    (lres[i])
    );
  end

  assign lanes_done = lres[0].done && lres[1].done && lres[2].done;
  assign empty      = count == '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (lanes_done) begin
        busy  <= 1'b0;
        done  <= 1'b1;
        count <= '0;
      end else begin
        if (pix_en) begin
          count <= count + 17'd1;
        end
        if (accept && last_pixel) begin
          busy <= 1'b1;
        end
      end
    end
  end

  // merge the lanes into one result word
  always_ff @(posedge clk) begin
    if (lanes_done) begin
      region_empty   <= empty;
      pixels_counted <= count;
      mean_a   <= empty ? '0 : lres[0].mean;
      mean_b   <= empty ? '0 : lres[1].mean;
      mean_c   <= empty ? '0 : lres[2].mean;
      spread_a <= empty ? '0 : lres[0].spread;
      spread_b <= empty ? '0 : lres[1].spread;
      spread_c <= empty ? '0 : lres[2].spread;
      skew_a   <= empty ? '0 : lres[0].skew;
      skew_b   <= empty ? '0 : lres[1].skew;
      skew_c   <= empty ? '0 : lres[2].skew;
    end
  end

`ifndef ASSERT_OFF
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("result shown while busy");
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy)) else $error("result without a region");
  a_lanes_in_step: assert property (@(posedge clk) disable iff (rst)
    lres[0].done |-> (lres[1].done && lres[2].done)) else $error("lanes out of step");
  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    (done && region_empty) |-> (pixels_counted == '0)) else $error("empty with count");
  a_count_limit: assert property (@(posedge clk) disable iff (rst)
    count <= MAX_REGION_PIXELS) else $error("count over limit");
`endif

endmodule
